// ===== hdl/rht_pkg.sv =====
// Shared types and constants for the randomised Hadamard transform block.
package rht_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAX_LOG2   = 6;
    localparam int DEPTH      = 1 << MAX_LOG2;
    localparam int ADDR_W     = MAX_LOG2;
    localparam int CNT_W      = MAX_LOG2 + 1;
    localparam int X_W        = SAMPLE_W + 1;
    localparam int VAL_W      = 23;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic signed [17:0] SQRT_HALF_Q16 = 18'sd46341;

    // register index codes (paddr[2])
    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_NORM = 1'b1;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [ADDR_W-1:0]     addr;
        logic                  last;
        logic [2:0]            k;
    } t_entry;

endpackage

// ===== hdl/rht_front.sv =====
// Front end: takes requests, applies sign, counts the row and tags its end.
module rht_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rht_pkg::SAMPLE_W-1:0]  s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,
    input  logic [2:0]                    i_size_log2,
    input  logic                          i_full,
    output logic                          o_push,
    output rht_pkg::t_entry               o_entry
);
    import rht_pkg::*;

    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      w_inc, w_len;
    logic [2:0]            w_k;
    logic signed [X_W-1:0] w_ext;
    logic                  w_last;

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

    assign w_k    = (i_size_log2 > 3'(MAX_LOG2)) ? 3'(MAX_LOG2) : i_size_log2;
    assign w_len  = CNT_W'(1) << w_k;
    assign w_inc  = r_cnt + CNT_W'(1);
    assign w_last = (w_inc >= w_len);
    assign w_ext  = X_W'($signed(s_axis_tdata));

    always_comb begin
        o_entry.x    = s_axis_tuser[0] ? -w_ext : w_ext;
        o_entry.addr = r_cnt[ADDR_W-1:0];
        o_entry.last = w_last;
        o_entry.k    = w_k;
        n_cnt        = r_cnt;
        if (o_push) begin
            n_cnt = w_last ? '0 : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CNT_W'(DEPTH)) else $error("row count out of range");

endmodule

// ===== hdl/rht_fifo.sv =====
// Short queue between front and back ends.
module rht_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rht_pkg::t_entry i_entry,
    input  logic            i_pop,
    output rht_pkg::t_entry o_entry,
    output logic            o_full,
    output logic            o_empty
);
    import rht_pkg::*;

    t_entry             r_q [FIFO_DEPTH];
    logic [FIFO_AW:0]   r_wp, r_rp;

    assign o_empty = (r_wp == r_rp);
    assign o_full  = (r_wp[FIFO_AW] != r_rp[FIFO_AW]) &&
                     (r_wp[FIFO_AW-1:0] == r_rp[FIFO_AW-1:0]);
    assign o_entry = r_q[r_rp[FIFO_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp[FIFO_AW-1:0]] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
        end
    end

    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_under: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");

endmodule

// ===== hdl/rht_back.sv =====
// Back end: row buffer, butterfly sequencer, normalisation and output register.
module rht_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rht_pkg::t_entry          i_entry,
    input  logic                     i_empty,
    output logic                     o_pop,
    input  logic                     i_normalize,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [23:0]              m_axis_tdata,
    output logic                     m_axis_tlast
);
    import rht_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_BF_RD, S_BF_WA, S_BF_WB, S_EM_RD, S_EM_MUL, S_EM_OUT
    } t_state;

    t_state                  r_state;
    logic [2:0]              r_k, r_stage;
    logic [ADDR_W-2:0]       r_idx;
    logic [ADDR_W-1:0]       r_i;
    logic                    r_norm, r_odd;
    logic signed [VAL_W-1:0] r_rda, r_rdb, r_sh;
    logic signed [40:0]      r_prod;
    logic                    r_m_tvalid, r_m_tlast;
    logic [VAL_W-1:0]        r_m_value;

    logic signed [VAL_W-1:0] r_mem [DEPTH];

    logic [ADDR_W-1:0]       w_lo, w_span, w_j, w_ra, w_rb, w_wa, w_len_m1;
    logic [ADDR_W-2:0]       w_half_m1;
    logic signed [VAL_W-1:0] w_wd, w_sh;
    logic signed [40:0]      w_prod;
    logic [1:0]              w_shamt;
    logic                    w_we, w_re, w_out_free;

    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_out_free = !r_m_tvalid || m_axis_tready;

    // butterfly addressing: insert a zero at bit 'stage' of the pair index
    assign w_span    = ADDR_W'(1) << r_stage;
    assign w_lo      = w_span - ADDR_W'(1);
    assign w_j       = ((ADDR_W'(r_idx) & ~w_lo) << 1) | (ADDR_W'(r_idx) & w_lo);
    assign w_half_m1 = (ADDR_W-1)'((ADDR_W'(1) << (r_k - 3'd1)) - ADDR_W'(1));
    assign w_len_m1  = ADDR_W'((CNT_W'(1) << r_k) - CNT_W'(1));

    assign w_shamt = r_norm ? r_k[2:1] : 2'd0;
    assign w_sh    = r_rda >>> w_shamt;
    assign w_prod  = w_sh * SQRT_HALF_Q16;

    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = '0;
        w_re = 1'b0;
        w_ra = w_j;
        w_rb = w_j | w_span;
        case (r_state)
            S_IDLE: begin
                w_we = o_pop;
                w_wa = i_entry.addr;
                w_wd = VAL_W'(i_entry.x);
            end
            S_BF_RD: w_re = 1'b1;
            S_BF_WA: begin
                w_we = 1'b1;
                w_wa = w_j;
                w_wd = r_rda + r_rdb;
            end
            S_BF_WB: begin
                w_we = 1'b1;
                w_wa = w_j | w_span;
                w_wd = r_rda - r_rdb;
            end
            S_EM_RD: begin
                w_re = 1'b1;
                w_ra = r_i;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rda <= r_mem[w_ra];
            r_rdb <= r_mem[w_rb];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            // a new result may replace the one taken in this cycle
            if (r_state == S_EM_OUT && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (r_m_tvalid && m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && i_entry.last) begin
                        r_k     <= i_entry.k;
                        r_norm  <= i_normalize;
                        r_odd   <= i_normalize && i_entry.k[0];
                        r_stage <= '0;
                        r_idx   <= '0;
                        r_i     <= '0;
                        r_state <= (i_entry.k == 3'd0) ? S_EM_RD : S_BF_RD;
                    end
                end
                S_BF_RD: r_state <= S_BF_WA;
                S_BF_WA: r_state <= S_BF_WB;
                S_BF_WB: begin
                    if (r_idx == w_half_m1) begin
                        r_idx <= '0;
                        if (r_stage == r_k - 3'd1) begin
                            r_state <= S_EM_RD;
                        end else begin
                            r_stage <= r_stage + 3'd1;
                            r_state <= S_BF_RD;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_BF_RD;
                    end
                end
                S_EM_RD: r_state <= S_EM_MUL;
                S_EM_MUL: begin
                    r_sh    <= w_sh;
                    r_prod  <= w_prod;
                    r_state <= S_EM_OUT;
                end
                S_EM_OUT: begin
                    if (w_out_free) begin
                        r_m_value  <= r_odd ? r_prod[38:16] : r_sh;
                        r_m_tlast  <= (r_i == w_len_m1);
                        if (r_i == w_len_m1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {1'b0, r_m_value};
    assign m_axis_tlast  = r_m_tlast;

    a_stage_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF_RD || r_state == S_BF_WA || r_state == S_BF_WB)
        |-> (r_stage < r_k)) else $error("butterfly stage beyond row size");
    a_emit_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_RD || r_state == S_EM_MUL || r_state == S_EM_OUT)
        |-> (r_i <= w_len_m1)) else $error("emit index beyond row");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EM_OUT && w_out_free && r_i == w_len_m1)
        |=> (r_state == S_IDLE && m_axis_tlast)) else $error("row end not marked");

endmodule

// ===== hdl/randomized_hadamard_transform_core.sv =====
// Top level: randomised Walsh-Hadamard transform core with APB register port.
// Requests enter the queue while it has room; the back end drains one per cycle while loading.
// A row of 2^k runs k*2^(k-1) butterflies (one write port on the row buffer), each a pair read,
// a sum write and a difference write; then each element is read, scaled and registered for output,
// waiting while the output is held. No new row is taken in until the last one has been emitted.
// Synchronous active-low reset clears counts, queue, sequencer and registers (size 6, plain mode).
module randomized_hadamard_transform_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic [0:0]  s_axis_tuser,   // [0] sign_neg
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [22:0] value, [23] zero
    output logic        m_axis_tlast,   // row_last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rht_pkg::*;

    logic [2:0] r_size_log2;
    logic       r_normalize;
    logic       w_push, w_pop, w_full, w_empty;
    t_entry     w_in_entry, w_q_entry;

    assign pready = 1'b1;

    // registers: size_log2 at 0x0, normalize at 0x4
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= 3'(MAX_LOG2);
            r_normalize <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SIZE: r_size_log2 <= pwdata[2:0];
                REG_NORM: r_normalize <= pwdata[0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SIZE: prdata = {29'd0, r_size_log2};
            REG_NORM: prdata = {31'd0, r_normalize};
            default:  prdata = '0;
        endcase
    end

    // front: sign, slot, end-of-row tag
    rht_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_size_log2   (r_size_log2),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_in_entry)
    );

    rht_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_entry (w_q_entry),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // back: buffer writes, butterflies, scaling, output
    rht_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_q_entry),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .i_normalize   (r_normalize),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
